/* hdl/assert_macros.svh */
// Assertion macros shared by the heap queue RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising edge outside reset.
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, cond) \
	`ASSERT_CLK(label, !(cond))

`endif

/* hdl/bmhq_pkg.sv */
// Package of the binary max-heap queue: payload structs, codes and
// controller/datapath command types. No dependencies.
`default_nettype none

package bmhq_pkg;

	// operation codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// result status codes
	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	localparam int CAP_W   = 9;
	localparam int OCC_W   = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef struct packed {
		logic        cmd;
		logic [15:0] key;
		logic [15:0] tag;
		logic [15:0] ref_req;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [15:0]      out_key;
		logic [15:0]      out_tag;
		logic [15:0]      out_ref;
		logic [OCC_W-1:0] occupancy;
	} out_item_t;

	// one heap entry as kept in the store
	typedef struct packed {
		logic [15:0] key;
		logic [15:0] tag;
		logic [15:0] handle;
	} entry_t;

	typedef enum logic [2:0] {
		RD_ROOT   = 3'd0,
		RD_LAST   = 3'd1,
		RD_PARENT = 3'd2,
		RD_LEFT   = 3'd3,
		RD_RIGHT  = 3'd4,
		RD_NLEFT  = 3'd5
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NEW  = 2'd0,
		WR_RD   = 2'd1,
		WR_CAND = 2'd2,
		WR_X    = 2'd3
	} wr_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD   = 3'd0,
		IDX_COUNT  = 3'd1,
		IDX_ZERO   = 3'd2,
		IDX_PARENT = 3'd3,
		IDX_CAND   = 3'd4
	} idx_op_t;

	// controller to datapath
	typedef struct packed {
		logic       load_req;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       wr_en;
		wr_sel_t    wr_sel;
		idx_op_t    idx_op;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_set;
		logic [1:0] res_status;
		logic       cap_root;
		logic       cap_x;
		logic       cand_left;
		logic       cand_right;
		logic       load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_insert;
		logic full;
		logic empty;
		logic idx_zero;
		logic up_move;
		logic left_ok;
		logic right_ok;
		logic nleft_ok;
		logic cand_child;
	} dp_sts_t;

endpackage

`default_nettype wire

/* hdl/binary_max_heap_queue_core.sv */
// Binary max-heap priority queue: top level joining controller and datapath.
// Depends on bmhq_pkg, bmhq_ctrl, bmhq_dpath.
//
// Usage:
//   in_valid/in_stall/in_data carry one operation: insert (key, tag, ref_req)
//   or remove the maximum entry. out_valid/out_stall/out_data return exactly
//   one result per operation: status, the removed entry (zero otherwise) and
//   the occupancy after the operation.
//   cfg_valid/cfg_ready/cfg_data write the capacity register; write it only
//   while no operation is in flight.
// Operation:
//   One operation is in flight at a time. An insert climbing the heap reads
//   the parent once per level; a remove descending it reads both children per
//   level, only the left one where the right child is missing.
// Reset clears the entry count and sets capacity to 256; store contents stay
// as they are and are never read before being written. While the receiver
// stalls, the result is held and the next operation waits before output.
`default_nettype none

module binary_max_heap_queue_core
	import bmhq_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_item_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;
	logic    cfg_we;

	// accept capacity writes at any time
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	bmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	bmhq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (dp_cmd),
		.sts      (dp_sts),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

/* hdl/bmhq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bmhq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/bmhq_ctrl.sv */
// Controller of the heap queue: sequences insert sift-up and remove sift-down.
// Depends on bmhq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bmhq_ctrl
	import bmhq_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_DISP   = 11'b000_0000_0010,
		S_UP_CHK = 11'b000_0000_0100,
		S_UP_CMP = 11'b000_0000_1000,
		S_DN_LST = 11'b000_0001_0000,
		S_DN_X   = 11'b000_0010_0000,
		S_DN_L   = 11'b000_0100_0000,
		S_DN_R   = 11'b000_1000_0000,
		S_DN_MV  = 11'b001_0000_0000,
		S_DN_FIN = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DISP;
				end
			end
			S_DISP: begin
				cmd.res_set = 1'b1;
				if (sts.is_insert) begin
					if (sts.full) begin
						cmd.res_status = STS_FULL;
						state_d        = S_DONE;
					end else begin
						cmd.res_status = STS_DONE;
						cmd.idx_op     = IDX_COUNT;
						cmd.cnt_inc    = 1'b1;
						state_d        = S_UP_CHK;
					end
				end else begin
					if (sts.empty) begin
						cmd.res_status = STS_EMPTY;
						state_d        = S_DONE;
					end else begin
						cmd.res_status = STS_DONE;
						cmd.rd_en      = 1'b1;
						cmd.rd_sel     = RD_ROOT;
						cmd.idx_op     = IDX_ZERO;
						cmd.cnt_dec    = 1'b1;
						state_d        = S_DN_LST;
					end
				end
			end
			S_UP_CHK: begin
				if (sts.idx_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_NEW;
					state_d    = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.up_move) begin
					cmd.wr_sel = WR_RD;
					cmd.idx_op = IDX_PARENT;
					state_d    = S_UP_CHK;
				end else begin
					cmd.wr_sel = WR_NEW;
					state_d    = S_DONE;
				end
			end
			S_DN_LST: begin
				cmd.cap_root = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RD_LAST;
				state_d      = S_DN_X;
			end
			S_DN_X: begin
				cmd.cap_x = 1'b1;
				if (sts.left_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEFT;
					state_d    = S_DN_L;
				end else if (!sts.empty) begin
					state_d = S_DN_FIN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DN_L: begin
				cmd.cand_left = 1'b1;
				if (sts.right_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RIGHT;
					state_d    = S_DN_R;
				end else begin
					state_d = S_DN_MV;
				end
			end
			S_DN_R: begin
				cmd.cand_right = 1'b1;
				state_d        = S_DN_MV;
			end
			S_DN_MV: begin
				cmd.wr_en = 1'b1;
				if (sts.cand_child) begin
					cmd.wr_sel = WR_CAND;
					cmd.idx_op = IDX_CAND;
					if (sts.nleft_ok) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_NLEFT;
						state_d    = S_DN_L;
					end else begin
						state_d = S_DN_FIN;
					end
				end else begin
					cmd.wr_sel = WR_X;
					state_d    = S_DONE;
				end
			end
			S_DN_FIN: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_X;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the result valid until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	`ASSERT_CLK(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE))
	`ASSERT_CLK(a_done_waits, (state_q == S_DONE && out_valid_q && out_stall) |=> state_q == S_DONE)
	`ASSERT_CLK(a_accept_dispatch, (in_valid && !in_stall) |=> state_q == S_DISP)

endmodule

`default_nettype wire

/* hdl/bmhq_dpath.sv */
// Datapath of the heap queue: entry store, index and count registers,
// comparators and the result register. Depends on bmhq_pkg, bmhq_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bmhq_dpath
	import bmhq_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire in_item_t         in_data,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_data,
	input  wire dp_cmd_t          cmd,
	output dp_sts_t               sts,
	output out_item_t             out_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = AW + 2;
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	in_item_t         req_q;
	logic [CAP_W-1:0] capacity_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    cand_idx_q;
	logic             cand_child_q;
	entry_t           cand_q;
	entry_t           x_q;
	entry_t           res_ent_q;
	logic [1:0]       res_status_q;
	out_item_t        out_q;

	entry_t        rd_ent;
	logic [$bits(entry_t)-1:0] rd_raw;
	entry_t        wr_ent;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] idx_m1;
	logic [AW-1:0] parent;
	logic [IW-1:0] left_w;
	logic [IW-1:0] right_w;
	logic [IW-1:0] nleft_w;
	logic [IW-1:0] cnt_w;
	logic [LW-1:0] limit;
	logic          lbig;

	// child and parent indexes of the current hole
	always_comb begin
		idx_m1  = idx_q - AW'(1);
		parent  = idx_m1 >> 1;
		left_w  = {1'b0, idx_q, 1'b1};
		right_w = IW'({idx_q, 1'b0}) + IW'(2);
		nleft_w = {1'b0, cand_idx_q, 1'b1};
		cnt_w   = IW'(count_q);
		limit   = (LW'(capacity_q) < LW'(DEPTH)) ? LW'(capacity_q) : LW'(DEPTH);
	end

	assign rd_ent = entry_t'(rd_raw);
	assign lbig   = rd_ent.key > x_q.key;

	// status toward the controller
	always_comb begin
		sts.is_insert  = (req_q.cmd == CMD_INSERT);
		sts.full       = (LW'(count_q) >= limit);
		sts.empty      = (count_q == '0);
		sts.idx_zero   = (idx_q == '0);
		sts.up_move    = (req_q.key > rd_ent.key);
		sts.left_ok    = (left_w < cnt_w);
		sts.right_ok   = (right_w < cnt_w);
		sts.nleft_ok   = (nleft_w < cnt_w);
		sts.cand_child = cand_child_q;
	end

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			RD_ROOT:   rd_addr = '0;
			RD_LAST:   rd_addr = count_q[AW-1:0];
			RD_PARENT: rd_addr = parent;
			RD_LEFT:   rd_addr = left_w[AW-1:0];
			RD_RIGHT:  rd_addr = right_w[AW-1:0];
			RD_NLEFT:  rd_addr = nleft_w[AW-1:0];
			default:   rd_addr = '0;
		endcase
	end

	// write data select; the write always lands on the hole
	always_comb begin
		case (cmd.wr_sel)
			WR_NEW:  wr_ent = '{key: req_q.key, tag: req_q.tag, handle: req_q.ref_req};
			WR_RD:   wr_ent = rd_ent;
			WR_CAND: wr_ent = cand_q;
			WR_X:    wr_ent = x_q;
			default: wr_ent = x_q;
		endcase
	end

	bmhq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (idx_q),
		.wr_data (wr_ent),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	// capacity register and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			count_q    <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// request, hole index, candidate and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_data;
		end
		case (cmd.idx_op)
			IDX_HOLD:   idx_q <= idx_q;
			IDX_COUNT:  idx_q <= count_q[AW-1:0];
			IDX_ZERO:   idx_q <= '0;
			IDX_PARENT: idx_q <= parent;
			IDX_CAND:   idx_q <= cand_idx_q;
			default:    idx_q <= idx_q;
		endcase
		if (cmd.cap_x) begin
			x_q <= rd_ent;
		end
		if (cmd.cand_left) begin
			cand_q       <= lbig ? rd_ent : x_q;
			cand_child_q <= lbig;
			cand_idx_q   <= left_w[AW-1:0];
		end else if (cmd.cand_right && (rd_ent.key > cand_q.key)) begin
			cand_q       <= rd_ent;
			cand_child_q <= 1'b1;
			cand_idx_q   <= right_w[AW-1:0];
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_ent_q    <= '0;
		end else if (cmd.cap_root) begin
			res_ent_q <= rd_ent;
		end
		if (cmd.load_out) begin
			out_q.status    <= res_status_q;
			out_q.out_key   <= res_ent_q.key;
			out_q.out_tag   <= res_ent_q.tag;
			out_q.out_ref   <= res_ent_q.handle;
			out_q.occupancy <= OCC_W'(count_q);
		end
	end

	assign out_data = out_q;

	`ASSERT_CLK(a_count_in_store, count_q <= CW'(DEPTH))
	`ASSERT_CLK(a_write_below_count, cmd.wr_en |-> (IW'(idx_q) < cnt_w))
	`ASSERT_NEVER(a_grow_when_full, cmd.cnt_inc && sts.full)

endmodule

`default_nettype wire

/* tb/sv/binary_max_heap_queue_core_tb.sv */
// Testbench for binary_max_heap_queue_core: directed and random insert/remove
// traffic checked against a behavioral max-heap kept inside the bench.
// Depends on bmhq_pkg and the RTL of the heap queue.
`default_nettype none

module binary_max_heap_queue_core_tb
	import bmhq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP_DEPTH = 256;
	localparam int SETTLE_CYC = 32;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	// behavioral heap mirroring the block
	entry_t mirror_heap [HEAP_DEPTH];
	int unsigned mirror_count = 0;
	logic [CAP_W-1:0] mirror_cap = CAP_RESET;

	out_item_t pending_results [$];
	int unsigned fail_count = 0;

	// sender and receiver pacing controls
	bit burst_mode = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_hold_cycles = 0;
	int rx_run = 0;

	binary_max_heap_queue_core #(
		.DEPTH(HEAP_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// hard limit on the run
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// Apply one operation to the mirror heap and return the result it yields.
	function automatic out_item_t apply_heap_op(in_item_t op);
		out_item_t res;
		int unsigned lim;
		int unsigned pos;
		int unsigned best;
		int unsigned lc;
		int unsigned rc;
		entry_t tmp;
		res = '0;
		res.status = STS_DONE;
		lim = (mirror_cap < HEAP_DEPTH) ? mirror_cap : HEAP_DEPTH;
		if (op.cmd == CMD_INSERT) begin
			if (mirror_count >= lim) begin
				res.status = STS_FULL;
			end else begin
				// climb while strictly greater than the parent
				pos = mirror_count;
				mirror_count++;
				while (pos > 0 && op.key > mirror_heap[(pos - 1) / 2].key) begin
					mirror_heap[pos] = mirror_heap[(pos - 1) / 2];
					pos = (pos - 1) / 2;
				end
				mirror_heap[pos] = '{key: op.key, tag: op.tag, handle: op.ref_req};
			end
		end else begin
			if (mirror_count == 0) begin
				res.status = STS_EMPTY;
			end else begin
				res.out_key = mirror_heap[0].key;
				res.out_tag = mirror_heap[0].tag;
				res.out_ref = mirror_heap[0].handle;
				mirror_count--;
				mirror_heap[0] = mirror_heap[mirror_count];
				// descend toward the larger child, left wins a tie
				pos = 0;
				forever begin
					best = pos;
					lc = 2 * pos + 1;
					rc = 2 * pos + 2;
					if (lc < mirror_count && mirror_heap[lc].key > mirror_heap[best].key)
						best = lc;
					if (rc < mirror_count && mirror_heap[rc].key > mirror_heap[best].key)
						best = rc;
					if (best == pos)
						break;
					tmp = mirror_heap[pos];
					mirror_heap[pos] = mirror_heap[best];
					mirror_heap[best] = tmp;
					pos = best;
				end
			end
		end
		res.occupancy = mirror_count[OCC_W-1:0];
		return res;
	endfunction

	function automatic in_item_t mk_insert(logic [15:0] k, logic [15:0] t, logic [15:0] r);
		in_item_t op;
		op.cmd = CMD_INSERT;
		op.key = k;
		op.tag = t;
		op.ref_req = r;
		return op;
	endfunction

	// remove with random don't-care payload
	function automatic in_item_t mk_remove();
		in_item_t op;
		op.cmd = CMD_REMOVE;
		op.key = 16'($urandom);
		op.tag = 16'($urandom);
		op.ref_req = 16'($urandom);
		return op;
	endfunction

	function automatic in_item_t rand_op(int ins_pct, int key_max);
		if ($urandom_range(0, 99) < ins_pct)
			return mk_insert(16'($urandom_range(0, key_max)), 16'($urandom), 16'($urandom));
		return mk_remove();
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// Offer one transaction; called and returns at a falling edge.
	task automatic send_op(in_item_t op);
		int gap;
		in_data = op;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(apply_heap_op(op));
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Hold off the input until every expected result is back.
	task automatic wait_drain();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] value);
		wait_drain();
		repeat (SETTLE_CYC) @(negedge clk);
		cfg_data = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mirror_cap = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Receiver pacing: forced hold, short random stalls, rare long ones.
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			out_stall = 1'b1;
			rx_hold_cycles = rx_hold_cycles - 1;
		end else if (rx_run > 0) begin
			out_stall = 1'b1;
			rx_run = rx_run - 1;
		end else if (rx_quiet) begin
			out_stall = 1'b0;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:69]: begin
					out_stall = 1'b0;
				end
				[70:96]: begin
					out_stall = 1'b1;
					rx_run = $urandom_range(0, 3);
				end
				default: begin
					out_stall = 1'b1;
					rx_run = $urandom_range(10, 40);
				end
			endcase
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("ERROR %0t: unexpected result sts=%0d key=%h tag=%h ref=%h occ=%0d",
						$realtime, out_data.status, out_data.out_key, out_data.out_tag,
						out_data.out_ref, out_data.occupancy);
			end else begin
				want = pending_results.pop_front();
				if (out_data.status !== want.status || out_data.out_key !== want.out_key ||
						out_data.out_tag !== want.out_tag || out_data.out_ref !== want.out_ref ||
						out_data.occupancy !== want.occupancy) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$write("MISMATCH %0t: exp sts=%0d key=%h tag=%h ref=%h occ=%0d",
							$realtime, want.status, want.out_key, want.out_tag,
							want.out_ref, want.occupancy);
						$display(" got sts=%0d key=%h tag=%h ref=%h occ=%0d",
							out_data.status, out_data.out_key, out_data.out_tag,
							out_data.out_ref, out_data.occupancy);
					end
				end
			end
		end
	end

	// Field extremes, equal keys, left child on a tie, empty removes.
	task automatic test_directed();
		send_op(mk_remove());
		send_op(mk_insert(16'h0000, 16'h0000, 16'h0000));
		send_op(mk_insert(16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_op(mk_insert(16'hAAAA, 16'h5555, 16'hAAAA));
		send_op(mk_insert(16'h5555, 16'hAAAA, 16'h5555));
		send_op(mk_insert(16'hFFFF, 16'h0001, 16'h0002));
		repeat (6) send_op(mk_remove());
		// both children tie above the moved entry
		send_op(mk_insert(16'd9, 16'd1, 16'd11));
		send_op(mk_insert(16'd7, 16'd2, 16'd12));
		send_op(mk_insert(16'd7, 16'd3, 16'd13));
		send_op(mk_insert(16'd1, 16'd4, 16'd14));
		repeat (5) send_op(mk_remove());
		wait_drain();
	endtask

	// Capacity of one, zero, and lowered below the occupancy.
	task automatic test_capacity_edges();
		set_capacity(9'd1);
		send_op(mk_insert(16'($urandom), 16'($urandom), 16'($urandom)));
		send_op(mk_insert(16'($urandom), 16'($urandom), 16'($urandom)));
		send_op(mk_remove());
		send_op(mk_remove());
		set_capacity(9'd0);
		send_op(mk_insert(16'($urandom), 16'($urandom), 16'($urandom)));
		send_op(mk_insert(16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_op(mk_remove());
		set_capacity(9'd256);
		repeat (20) send_op(mk_insert(16'($urandom), 16'($urandom), 16'($urandom)));
		set_capacity(9'd5);
		send_op(mk_insert(16'($urandom), 16'($urandom), 16'($urandom)));
		repeat (16) send_op(mk_remove());
		send_op(mk_insert(16'($urandom), 16'($urandom), 16'($urandom)));
		send_op(mk_insert(16'($urandom), 16'($urandom), 16'($urandom)));
		repeat (6) send_op(mk_remove());
		wait_drain();
	endtask

	// Capacity beyond the store: fill every entry, then empty it again.
	task automatic test_store_full();
		set_capacity(9'd511);
		repeat (HEAP_DEPTH + 2)
			send_op(mk_insert(16'($urandom_range(0, ($urandom_range(0, 1) != 0) ? 65535 : 31)),
				16'($urandom), 16'($urandom)));
		set_capacity(9'd300);
		send_op(mk_insert(16'($urandom), 16'($urandom), 16'($urandom)));
		repeat (HEAP_DEPTH + 2) send_op(mk_remove());
		wait_drain();
	endtask

	// Long receiver hold while the sender keeps offering; then a full pause.
	task automatic test_backpressure();
		set_capacity(9'd256);
		burst_mode = 1'b1;
		rx_hold_cycles = 250;
		repeat (12) send_op(mk_insert(16'($urandom), 16'($urandom), 16'($urandom)));
		burst_mode = 1'b0;
		wait_drain();
		repeat (4) send_op(mk_remove());
		wait_drain();
		repeat (8) send_op(mk_remove());
		wait_drain();
	endtask

	// Random phases at several capacities, insert mixes and key spreads.
	task automatic test_random_mix();
		logic [CAP_W-1:0] caps [5];
		int ins_pct [5] = '{60, 80, 25, 55, 50};
		int key_max [5] = '{65535, 65535, 15, 255, 65535};
		caps = '{9'd3, 9'd256, 9'd256, 9'd16, CAP_W'($urandom_range(1, 511))};
		for (int ph = 0; ph < 5; ph++) begin
			set_capacity(caps[ph]);
			burst_mode = (ph == 2);
			rx_quiet = (ph == 2);
			repeat (130) send_op(rand_op(ins_pct[ph], key_max[ph]));
		end
		burst_mode = 1'b0;
		rx_quiet = 1'b0;
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_capacity_edges();
		test_store_full();
		test_backpressure();
		test_random_mix();

		wait_drain();
		repeat (SETTLE_CYC) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
